// ----- rtl/fdd_pkg.sv -----
// Shared types, constants and byte helpers for the FAT directory entry decoder.
// No dependencies.
package fdd_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [POS_W-1:0] POS_FIRST      = 5'd0;
  localparam logic [POS_W-1:0] POS_EXT_FIRST  = 5'd8;
  localparam logic [POS_W-1:0] POS_ATTR       = 5'd11;
  localparam logic [POS_W-1:0] POS_CLUSTER_LO = 5'd26;
  localparam logic [POS_W-1:0] POS_CLUSTER_HI = 5'd27;
  localparam logic [POS_W-1:0] POS_SIZE_FIRST = 5'd28;
  localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

  localparam int unsigned DIR_BIT = 4;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] KANJI_MARK   = 8'h05;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FILE    = 2'd2,
    ST_DIR     = 2'd3
  } status_t;

  typedef struct packed {
    logic        done;
    logic        bad;
    logic        is_dir;
    logic [15:0] cluster;
    logic [31:0] size;
    logic [23:0] ext;
    logic [63:0] name;
  } entry_t;

  function automatic logic is_forbidden(input logic [7:0] c);
    logic hit;
    case (c)
      8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
      8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [3:0] name_trim_len(input logic [63:0] name);
    logic [3:0] len;
    logic       trailing;
    len      = 4'd8;
    trailing = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (trailing && name[i*8 +: 8] == SPACE_CHAR) begin
        len = 4'(i);
      end else begin
        trailing = 1'b0;
      end
    end
    return len;
  endfunction

  function automatic logic [1:0] ext_trim_len(input logic [23:0] ext);
    logic [1:0] len;
    logic       trailing;
    len      = 2'd3;
    trailing = 1'b1;
    for (int i = 2; i >= 0; i--) begin
      if (trailing && ext[i*8 +: 8] == SPACE_CHAR) begin
        len = 2'(i);
      end else begin
        trailing = 1'b0;
      end
    end
    return len;
  endfunction

  function automatic logic [63:0] keep_name(input logic [63:0] name, input logic [3:0] len);
    logic [63:0] kept;
    for (int i = 0; i < 8; i++) begin
      kept[i*8 +: 8] = (4'(i) < len) ? name[i*8 +: 8] : 8'h00;
    end
    return kept;
  endfunction

  function automatic logic [23:0] keep_ext(input logic [23:0] ext, input logic [1:0] len);
    logic [23:0] kept;
    for (int i = 0; i < 3; i++) begin
      kept[i*8 +: 8] = (2'(i) < len) ? ext[i*8 +: 8] : 8'h00;
    end
    return kept;
  endfunction

endpackage

// ----- rtl/fdd_entry_if.sv -----
// Byte request channel of the directory entry decoder.
// Depends on fdd_pkg.
interface fdd_entry_if import fdd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] entry_byte;
  logic       entry_start;

  modport source (output valid, output entry_byte, output entry_start, input ready);
  modport sink (input valid, input entry_byte, input entry_start, output ready);
endinterface

// ----- rtl/fdd_record_if.sv -----
// Record request channel of the directory entry decoder.
// Depends on fdd_pkg.
interface fdd_record_if import fdd_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] first_cluster;
  logic [31:0] file_size;
  logic [63:0] name_chars;
  logic [3:0]  name_length;
  logic [23:0] ext_chars;
  logic [1:0]  ext_length;

  modport source (output valid, output status, output first_cluster, output file_size,
                  output name_chars, output name_length, output ext_chars,
                  output ext_length, input ready);
  modport sink (input valid, input status, input first_cluster, input file_size,
                input name_chars, input name_length, input ext_chars,
                input ext_length, output ready);
endinterface

// ----- rtl/fdd_accum.sv -----
// Input register, byte position counter and raw entry field stores.
// Depends on fdd_pkg and fdd_entry_if.
module fdd_accum import fdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fdd_entry_if.sink  entry,
  input  logic       take,
  output entry_t     fields
);

  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             stage_start;
  logic [POS_W-1:0] position;
  logic [63:0]      name;
  logic [23:0]      ext;
  logic             is_dir;
  logic [15:0]      cluster;
  logic [31:0]      size;
  logic             bad;

  logic [POS_W-1:0] pos;
  logic             last;
  logic             advance;
  logic [63:0]      name_next;
  logic [23:0]      ext_next;
  logic             is_dir_next;
  logic [15:0]      cluster_next;
  logic [31:0]      size_next;
  logic             bad_next;

  assign pos     = stage_start ? POS_FIRST : position;
  assign last    = (pos == POS_LAST);
  assign advance = stage_valid && (!last || take);
  assign entry.ready = !stage_valid || advance;

  always_comb begin
    logic first;
    first        = (pos == POS_FIRST);
    name_next    = first ? '0 : name;
    ext_next     = first ? '0 : ext;
    is_dir_next  = first ? 1'b0 : is_dir;
    cluster_next = first ? '0 : cluster;
    size_next    = first ? '0 : size;
    bad_next     = first ? 1'b0 : bad;
    if (pos < POS_EXT_FIRST) begin
      name_next[pos[2:0]*8 +: 8] = stage_byte;
      bad_next = bad_next | is_forbidden(stage_byte);
    end else if (pos < POS_ATTR) begin
      ext_next[pos[1:0]*8 +: 8] = stage_byte;
    end else if (pos == POS_ATTR) begin
      is_dir_next = stage_byte[DIR_BIT];
    end else if (pos == POS_CLUSTER_LO || pos == POS_CLUSTER_HI) begin
      cluster_next[pos[0]*8 +: 8] = stage_byte;
    end else if (pos >= POS_SIZE_FIRST) begin
      size_next[pos[1:0]*8 +: 8] = stage_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      position    <= POS_FIRST;
    end else begin
      if (entry.valid && entry.ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        position <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry.valid && entry.ready) begin
      stage_byte  <= entry.entry_byte;
      stage_start <= entry.entry_start;
    end
    if (advance) begin
      name    <= name_next;
      ext     <= ext_next;
      is_dir  <= is_dir_next;
      cluster <= cluster_next;
      size    <= size_next;
      bad     <= bad_next;
    end
  end

  assign fields = '{
    done:    stage_valid && last,
    bad:     bad_next,
    is_dir:  is_dir_next,
    cluster: cluster_next,
    size:    size_next,
    ext:     ext_next,
    name:    name_next
  };

endmodule

// ----- rtl/fdd_classify.sv -----
// Trim, classify and hold one finished entry in the record register.
// Depends on fdd_pkg and fdd_record_if.
module fdd_classify import fdd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  entry_t       fields,
  output logic         take,
  fdd_record_if.source record
);

  logic        rec_valid;
  status_t     status_next;
  logic [3:0]  nlen;
  logic [1:0]  elen;
  logic [63:0] nchars;
  logic [23:0] echars;
  logic        keep;

  assign take = !rec_valid || record.ready;

  always_comb begin
    logic [7:0] first;
    nlen   = name_trim_len(fields.name);
    elen   = ext_trim_len(fields.ext);
    nchars = keep_name(fields.name, nlen);
    echars = keep_ext(fields.ext, elen);
    first  = nchars[7:0];
    priority if (fields.bad) begin
      status_next = ST_INVALID;
    end else if (!fields.is_dir && (first == DELETED_MARK || fields.size == '0)) begin
      status_next = ST_SKIPPED;
    end else if (fields.is_dir) begin
      status_next = ST_DIR;
      if (first == KANJI_MARK) begin
        nchars[7:0] = DELETED_MARK;
      end
    end else begin
      status_next = ST_FILE;
    end
    keep = (status_next == ST_FILE) || (status_next == ST_DIR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (fields.done && take) begin
      rec_valid <= 1'b1;
    end else if (record.ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fields.done && take) begin
      record.status        <= status_next;
      record.first_cluster <= keep ? fields.cluster : '0;
      record.file_size     <= keep ? fields.size : '0;
      record.name_chars    <= keep ? nchars : '0;
      record.name_length   <= keep ? nlen : '0;
      record.ext_chars     <= keep ? echars : '0;
      record.ext_length    <= keep ? elen : '0;
    end
  end

  assign record.valid = rec_valid;

endmodule

// ----- rtl/fat_dir_entry_decoder.sv -----
// Top level of the FAT directory entry decoder.
// Depends on fdd_pkg, fdd_entry_if, fdd_record_if, fdd_accum and fdd_classify.
//
// Takes one entry byte per cycle, save while a last byte holds (see below),
// and gives one record after byte 31 of each entry. A byte is held in the
// input register, then placed in the field stores; the last byte of an entry
// goes through trimming and classification in the same cycle and lands in
// the record register, which is loaded as byte 31 leaves the input register.
// The record register is the only buffer on the output: while a record
// waits, bytes keep flowing until the next entry's last byte, which holds
// until the record is taken. entry_start restarts the byte position and
// drops any partial entry; without it the position wraps after byte 31.
module fat_dir_entry_decoder import fdd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fdd_entry_if.sink    entry,
  fdd_record_if.source record
);

  entry_t fields;
  logic   take;

  fdd_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry),
    .take   (take),
    .fields (fields)
  );

  fdd_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .fields (fields),
    .take   (take),
    .record (record)
  );

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    fields.done && !take |-> !entry.ready)
    else $error("input taken while last byte is blocked");

  a_last_lands: assert property (@(posedge clk) disable iff (rst)
    fields.done && take |=> record.valid)
    else $error("finished entry produced no record");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    record.valid && (record.status == ST_INVALID || record.status == ST_SKIPPED)
    |-> record.file_size == '0 && record.name_length == '0 && record.ext_length == '0)
    else $error("dropped record carries data");

  a_file_size: assert property (@(posedge clk) disable iff (rst)
    record.valid && record.status == ST_FILE |-> record.file_size != '0)
    else $error("empty file reported as file");

endmodule
